/* design/eps_pkg.sv */
`timescale 1ns / 1ps
package eps_pkg;

   localparam int UTIL_W   = 32;
   localparam int COEF_W   = 32;
   localparam int LOSS_W   = 48;
   localparam int SCALE_W  = 32;
   localparam int MULT_W   = 16;
   localparam int PERIOD_W = 48;
   localparam int CFG_W    = 5;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_STEPS = 60;
   localparam int DIV_CNT_W = 6;

   localparam logic [1:0] ACT_LOAD_CHAIN = 2'd0;
   localparam logic [1:0] ACT_LOAD_MULT  = 2'd1;
   localparam logic [1:0] ACT_QUERY      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHAINS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASKS_IN_USE  = 1'd1;

   localparam logic signed [LOSS_W-1:0] LOSS_MAX = {1'b0, {(LOSS_W-1){1'b1}}};
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

   typedef struct packed {
      logic [1:0]               action;
      logic [3:0]               chain_slot;
      logic [UTIL_W-1:0]        lower_util;
      logic [UTIL_W-1:0]        upper_util;
      logic [COEF_W-1:0]        quad_coef;
      logic [COEF_W-1:0]        lin_coef;
      logic signed [LOSS_W-1:0] floor_loss;
      logic [SCALE_W-1:0]       sum_of_periods;
      logic [3:0]               task_slot;
      logic [MULT_W-1:0]        task_multiplier;
      logic [UTIL_W-1:0]        util_request;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [3:0]          chosen_chain;
      logic [3:0]          task_number;
      logic [PERIOD_W-1:0] task_period;
      logic                period_clipped;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [UTIL_W-1:0]        low;
      logic [UTIL_W-1:0]        high;
      logic [COEF_W-1:0]        quad;
      logic [COEF_W-1:0]        lin;
      logic signed [LOSS_W-1:0] floor_loss;
      logic [SCALE_W-1:0]       scale;
   } chain_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_MUL1,
      ST_MUL2,
      ST_COMPARE,
      ST_SCAN_END,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_TASK_READ,
      ST_TASK_MUL,
      ST_TASK_LOAD,
      ST_TASK_EMIT,
      ST_REJECT
   } state_type;

   typedef struct packed {
      logic accept;
      logic start_scan;
      logic mul1;
      logic mul2;
      logic compare;
      logic div_init;
      logic div_step;
      logic div_finish;
      logic task_mul;
      logic load_period;
      logic load_reject;
      logic next_task;
   } cmd_type;

   typedef struct packed {
      logic req_query;
      logic early_reject;
      logic have;
      logic last_chain;
      logic div_done;
      logic last_task;
   } status_type;

endpackage

/* design/eps_ram.sv */
`timescale 1ns / 1ps
module eps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/eps_datapath.sv */
`timescale 1ns / 1ps
module eps_datapath
   import eps_pkg::*;
#(
   parameter int MAX_CHAINS = 16,
   parameter int MAX_TASKS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  cmd_type              cmd,
   output status_type           status,
   output rsp_type              rsp_data
);

   localparam int CW    = (MAX_CHAINS > 1) ? $clog2(MAX_CHAINS) : 1;
   localparam int MDEP  = MAX_CHAINS * MAX_TASKS;
   localparam int MW    = (MDEP > 1) ? $clog2(MDEP) : 1;
   localparam int CNT_W = $clog2(MAX_CHAINS + 1);
   localparam int NCH_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int TASK_LIM = (MAX_TASKS < 16) ? MAX_TASKS : 16;

   // Configuration registers.
   logic [CFG_W-1:0] chains_cfg_ff, tasks_cfg_ff;
   logic [NCH_W-1:0] nch_in;
   logic [CFG_W-1:0] nt_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chains_cfg_ff <= CFG_W'(1);
         tasks_cfg_ff  <= CFG_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CHAINS_IN_USE: chains_cfg_ff <= csr_data;
            CSR_TASKS_IN_USE:  tasks_cfg_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (NCH_W'(chains_cfg_ff) > NCH_W'(MAX_CHAINS)) begin
         nch_in = NCH_W'(MAX_CHAINS);
      end else begin
         nch_in = NCH_W'(chains_cfg_ff);
      end
      if (tasks_cfg_ff == '0) begin
         nt_in = CFG_W'(1);
      end else if (tasks_cfg_ff > CFG_W'(TASK_LIM)) begin
         nt_in = CFG_W'(TASK_LIM);
      end else begin
         nt_in = tasks_cfg_ff;
      end
   end

   // Table writes happen in the cycle the load transfer completes.
   logic            chain_wr_en, mult_wr_en;
   chain_entry_type chain_wr_data, chain_rd;
   logic [MULT_W-1:0] mult_rd;
   logic [CW-1:0]   chain_cnt_ff, best_ff;
   logic [3:0]      task_cnt_ff;
   logic [MW-1:0]   mult_wr_addr, mult_rd_addr;
   logic            slot_ok, task_ok;

   assign slot_ok = (9'(req_data.chain_slot) < 9'(MAX_CHAINS));
   assign task_ok = (7'(req_data.task_slot) < 7'(MAX_TASKS));
   assign chain_wr_en = cmd.accept && (req_data.action == ACT_LOAD_CHAIN) && slot_ok;
   assign mult_wr_en  = cmd.accept && (req_data.action == ACT_LOAD_MULT) && slot_ok && task_ok;

   assign chain_wr_data = '{low: req_data.lower_util, high: req_data.upper_util,
                            quad: req_data.quad_coef, lin: req_data.lin_coef,
                            floor_loss: req_data.floor_loss,
                            scale: req_data.sum_of_periods};

   assign mult_wr_addr = MW'(32'(req_data.chain_slot) * 32'(MAX_TASKS)
                             + 32'(req_data.task_slot));
   assign mult_rd_addr = MW'(32'(best_ff) * 32'(MAX_TASKS) + 32'(task_cnt_ff));

   eps_ram #(.WIDTH($bits(chain_entry_type)), .DEPTH(MAX_CHAINS)) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_wr_en),
      .wr_addr (CW'(req_data.chain_slot)),
      .wr_data (chain_wr_data),
      .rd_addr (chain_cnt_ff),
      .rd_data (chain_rd)
   );

   eps_ram #(.WIDTH(MULT_W), .DEPTH(MDEP)) u_mult_ram (
      .clock   (clock),
      .wr_en   (mult_wr_en),
      .wr_addr (mult_wr_addr),
      .wr_data (req_data.task_multiplier),
      .rd_addr (mult_rd_addr),
      .rd_data (mult_rd)
   );

   // Running minimum of loaded lower bounds and the latched query limit.
   logic [UTIL_W-1:0] lowest_ff, u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff <= '1;
      end else if (chain_wr_en && (req_data.lower_util < lowest_ff)) begin
         lowest_ff <= req_data.lower_util;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         u_ff <= req_data.util_request;
      end
   end

   // Loss evaluation: two multiplier stages, then compare.
   logic [63:0] prod1_ff, prod2_ff, prod3_ff;
   logic [47:0] quad_in;
   logic [43:0] lin_in;
   logic signed [49:0] diff_in;
   logic signed [LOSS_W-1:0] loss_in, best_loss_ff;
   logic eligible_in, better_in, have_ff;
   logic [UTIL_W-1:0] best_high_ff;
   logic [SCALE_W-1:0] best_scale_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff <= 64'(chain_rd.quad) * 64'(u_ff);
         prod3_ff <= 64'(chain_rd.lin) * 64'(u_ff);
      end
      if (cmd.mul2) begin
         prod2_ff <= 64'(prod1_ff[63:32]) * 64'(u_ff);
      end
   end

   always_comb begin
      quad_in = prod2_ff[63:16];
      lin_in  = prod3_ff[63:20];
      diff_in = $signed({2'b00, quad_in}) - $signed({6'b000000, lin_in});
      if (u_ff > chain_rd.high) begin
         loss_in = chain_rd.floor_loss;
      end else if (diff_in > 50'(LOSS_MAX)) begin
         loss_in = LOSS_MAX;
      end else begin
         loss_in = diff_in[LOSS_W-1:0];
      end
      eligible_in = !(u_ff < chain_rd.low);
      better_in   = eligible_in && (!have_ff || (loss_in < best_loss_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         chain_cnt_ff <= '0;
      end else if (cmd.start_scan) begin
         have_ff      <= 1'b0;
         chain_cnt_ff <= '0;
      end else if (cmd.compare) begin
         if (better_in) begin
            have_ff <= 1'b1;
         end
         if (!status.last_chain) begin
            chain_cnt_ff <= chain_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare && better_in) begin
         best_ff       <= chain_cnt_ff;
         best_loss_ff  <= loss_in;
         best_high_ff  <= chain_rd.high;
         best_scale_ff <= chain_rd.scale;
      end
   end

   // Restoring divider for the base period, one quotient bit per cycle.
   logic [UTIL_W-1:0]    uc_in, uc_ff, rem_ff, rem_in;
   logic [DIV_STEPS-1:0] dq_ff;
   logic [UTIL_W:0]      trial_in;
   logic                 qbit_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [PERIOD_W-1:0]  base_ff;
   logic                 base_clip_ff;

   always_comb begin
      uc_in    = (u_ff >= best_high_ff) ? best_high_ff : u_ff;
      trial_in = {rem_ff, dq_ff[DIV_STEPS-1]};
      qbit_in  = (trial_in >= {1'b0, uc_ff});
      if (qbit_in) begin
         rem_in = UTIL_W'(trial_in - {1'b0, uc_ff});
      end else begin
         rem_in = trial_in[UTIL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_init) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         uc_ff  <= uc_in;
         rem_ff <= '0;
         dq_ff  <= {best_scale_ff, 28'd0};
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[DIV_STEPS-2:0], qbit_in};
      end
      if (cmd.div_finish) begin
         if ((uc_ff == '0) || (dq_ff[DIV_STEPS-1:PERIOD_W] != '0)) begin
            base_ff      <= PERIOD_MAX;
            base_clip_ff <= 1'b1;
         end else begin
            base_ff      <= dq_ff[PERIOD_W-1:0];
            base_clip_ff <= 1'b0;
         end
      end
   end

   // Per-task periods.
   logic [63:0] tprod_ff;
   rsp_type     rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_cnt_ff <= '0;
      end else if (cmd.div_init) begin
         task_cnt_ff <= '0;
      end else if (cmd.next_task) begin
         task_cnt_ff <= task_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.task_mul) begin
         tprod_ff <= 64'(base_ff) * 64'(mult_rd);
      end
      if (cmd.load_reject) begin
         rsp_ff <= '{found: 1'b0, chosen_chain: 4'd0, task_number: 4'd0,
                     task_period: '0, period_clipped: 1'b0, last: 1'b1};
      end else if (cmd.load_period) begin
         rsp_ff.found        <= 1'b1;
         rsp_ff.chosen_chain <= 4'(best_ff);
         rsp_ff.task_number  <= task_cnt_ff;
         rsp_ff.last         <= status.last_task;
         if (task_cnt_ff == 4'd0) begin
            rsp_ff.task_period    <= base_ff;
            rsp_ff.period_clipped <= base_clip_ff;
         end else if (tprod_ff[63:PERIOD_W] != '0) begin
            rsp_ff.task_period    <= PERIOD_MAX;
            rsp_ff.period_clipped <= 1'b1;
         end else begin
            rsp_ff.task_period    <= tprod_ff[PERIOD_W-1:0];
            rsp_ff.period_clipped <= base_clip_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

   assign status.req_query    = (req_data.action == ACT_QUERY);
   assign status.early_reject = (u_ff < lowest_ff) || (nch_in == '0);
   assign status.have         = have_ff;
   assign status.last_chain   = ((NCH_W'(chain_cnt_ff) + NCH_W'(1)) == nch_in);
   assign status.div_done     = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS)) || (uc_ff == '0);
   assign status.last_task    = ((CFG_W'(task_cnt_ff) + CFG_W'(1)) == nt_in);

endmodule

/* design/eps_controller.sv */
`timescale 1ns / 1ps
module eps_controller
   import eps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.req_query) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:     state_in = status.early_reject ? ST_REJECT : ST_READ;
         ST_READ:      state_in = ST_MUL1;
         ST_MUL1:      state_in = ST_MUL2;
         ST_MUL2:      state_in = ST_COMPARE;
         ST_COMPARE:   state_in = status.last_chain ? ST_SCAN_END : ST_READ;
         ST_SCAN_END:  state_in = status.have ? ST_DIV_INIT : ST_REJECT;
         ST_DIV_INIT:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_TASK_READ;
            end
         end
         ST_TASK_READ: state_in = ST_TASK_MUL;
         ST_TASK_MUL:  state_in = ST_TASK_LOAD;
         ST_TASK_LOAD: state_in = ST_TASK_EMIT;
         ST_TASK_EMIT: begin
            if (rsp_ready) begin
               state_in = status.last_task ? ST_IDLE : ST_TASK_READ;
            end
         end
         ST_REJECT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CHECK: begin
            cmd.load_reject = status.early_reject;
            cmd.start_scan  = !status.early_reject;
         end
         ST_MUL1:      cmd.mul1 = 1'b1;
         ST_MUL2:      cmd.mul2 = 1'b1;
         ST_COMPARE:   cmd.compare = 1'b1;
         ST_SCAN_END:  begin
            cmd.div_init    = status.have;
            cmd.load_reject = !status.have;
         end
         ST_DIVIDE: begin
            cmd.div_step   = !status.div_done;
            cmd.div_finish = status.div_done;
         end
         ST_TASK_MUL:  cmd.task_mul = 1'b1;
         ST_TASK_LOAD: cmd.load_period = 1'b1;
         ST_TASK_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.next_task = rsp_ready && !status.last_task;
         end
         ST_REJECT:    rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

/* design/elastic_period_selector.sv */
`timescale 1ns / 1ps
// Load items are taken while idle and produce no result. A query checks the request,
// then reads, multiplies twice and compares each chain searched, sets up and runs the
// divider, then reads, multiplies, loads and emits each period, waiting on any output stall.
// One item is worked at a time; the chain scan and the bit-serial divider set the rate.
// Synchronous active-high reset returns the controller to idle, sets both counts to 1
// and the lowest loaded bound to all ones; table contents are undefined until written.
module elastic_period_selector
   import eps_pkg::*;
#(
   parameter int MAX_CHAINS = 16,
   parameter int MAX_TASKS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   cmd_type    cmd;
   status_type status;

   eps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   eps_datapath #(.MAX_CHAINS(MAX_CHAINS), .MAX_TASKS(MAX_TASKS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/eps_checker.sv */
`timescale 1ns / 1ps
module eps_checker
   import eps_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_type              rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CFG_W-1:0]     csr_data
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // No new item is taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("request taken during result transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last && rsp_data.task_period == '0
         && rsp_data.chosen_chain == 4'd0)
      else $error("malformed reject result");

endmodule

bind elastic_period_selector eps_checker u_eps_checker (.*);

/* sim/tb_elastic_period_selector.sv */
`timescale 1ns / 1ps
module tb_elastic_period_selector;
   import eps_pkg::*;

   // Holds a copy of the chain tables and counts, works out the periods that each
   // accepted query must give, and compares every result transfer against them.
   class period_scoreboard;
      logic [UTIL_W-1:0]        low_t[16];
      logic [UTIL_W-1:0]        high_t[16];
      logic [COEF_W-1:0]        quad_t[16];
      logic [COEF_W-1:0]        lin_t[16];
      logic signed [LOSS_W-1:0] floor_t[16];
      logic [SCALE_W-1:0]       scale_t[16];
      logic [MULT_W-1:0]        mult_t[256];
      logic [UTIL_W-1:0]        lowest;
      logic [CFG_W-1:0]         chains;
      logic [CFG_W-1:0]         tasks;
      rsp_type                  periods_due[$];
      int                       errors;

      function new();
         lowest = '1;
         chains = CFG_W'(1);
         tasks = CFG_W'(1);
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
         if (idx == CSR_CHAINS_IN_USE) chains = v;
         else tasks = v;
      endfunction

      function bit idle();
         return periods_due.size() == 0;
      endfunction

      function void add_expected(rsp_type e);
         periods_due = {periods_due, e};
      endfunction

      function longint loss_of(int c, logic [UTIL_W-1:0] u);
         logic [63:0] p;
         logic [63:0] q;
         logic [63:0] l;
         longint r;
         if (u > high_t[c]) return longint'(floor_t[c]);
         p = 64'(quad_t[c]) * 64'(u);
         q = ((p >> 32) * 64'(u)) >> 16;
         l = (64'(lin_t[c]) * 64'(u)) >> 20;
         r = longint'(q) - longint'(l);
         if (r > longint'(LOSS_MAX)) r = longint'(LOSS_MAX);
         return r;
      endfunction

      function void note_request(req_type r);
         int nch;
         int nt;
         int best;
         bit have;
         longint best_loss;
         longint ls;
         logic [UTIL_W-1:0] uc;
         logic [63:0] base;
         logic [63:0] per;
         bit base_clip;
         rsp_type e;
         case (r.action)
            ACT_LOAD_CHAIN: begin
               low_t[r.chain_slot] = r.lower_util;
               high_t[r.chain_slot] = r.upper_util;
               quad_t[r.chain_slot] = r.quad_coef;
               lin_t[r.chain_slot] = r.lin_coef;
               floor_t[r.chain_slot] = r.floor_loss;
               scale_t[r.chain_slot] = r.sum_of_periods;
               if (r.lower_util < lowest) lowest = r.lower_util;
            end
            ACT_LOAD_MULT: begin
               mult_t[{r.chain_slot, r.task_slot}] = r.task_multiplier;
            end
            ACT_QUERY: begin
               nch = (chains > 16) ? 16 : chains;
               nt = (tasks == 0) ? 1 : ((tasks > 16) ? 16 : tasks);
               have = 0;
               best = 0;
               best_loss = 0;
               if (r.util_request >= lowest) begin
                  for (int c = 0; c < nch; c++) begin
                     if (r.util_request < low_t[c]) continue;
                     ls = loss_of(c, r.util_request);
                     if (!have || ls < best_loss) begin
                        have = 1;
                        best_loss = ls;
                        best = c;
                     end
                  end
               end
               if (!have) begin
                  e = '0;
                  e.last = 1'b1;
                  add_expected(e);
               end else begin
                  uc = (r.util_request >= high_t[best]) ? high_t[best] : r.util_request;
                  base_clip = 0;
                  if (uc == 0) begin
                     base = 64'(PERIOD_MAX);
                     base_clip = 1;
                  end else begin
                     base = (64'(scale_t[best]) << 28) / 64'(uc);
                     if (base > 64'(PERIOD_MAX)) begin
                        base = 64'(PERIOD_MAX);
                        base_clip = 1;
                     end
                  end
                  for (int t = 0; t < nt; t++) begin
                     e.found = 1'b1;
                     e.chosen_chain = best[3:0];
                     e.task_number = t[3:0];
                     e.period_clipped = base_clip;
                     per = base;
                     if (t > 0) begin
                        per = base * 64'(mult_t[best * 16 + t]);
                        if (per > 64'(PERIOD_MAX)) begin
                           per = 64'(PERIOD_MAX);
                           e.period_clipped = 1'b1;
                        end
                     end
                     e.task_period = per[PERIOD_W-1:0];
                     e.last = (t + 1 == nt);
                     add_expected(e);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         bit bad;
         if (periods_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer: %p", a);
            return;
         end
         e = periods_due.pop_front();
         bad = (a.found !== e.found) || (a.chosen_chain !== e.chosen_chain) ||
               (a.task_number !== e.task_number) || (a.task_period !== e.task_period) ||
               (a.period_clipped !== e.period_clipped) || (a.last !== e.last);
         if (bad) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p, got %p", e, a);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   period_scoreboard sb = new();
   bit calm_send = 0;
   bit calm_recv = 0;

   elastic_period_selector dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: unless calm_recv is set, may stall a random number of cycles before each transfer.
   initial begin
      int w;
      wait (!reset);
      @(posedge clock);
      forever begin
         w = calm_recv ? 0 : $urandom_range(0, 9);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   // Valid is left high after a transfer when no gap follows, so a back-to-back
   // item only updates the payload.
   task automatic send_req(input req_type r);
      int g;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      g = calm_send ? 0 : $urandom_range(0, 9);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (!sb.idle()) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_register(idx, v);
      @(posedge clock);
   endtask

   function automatic req_type noise_item();
      req_type r;
      r.action = 2'($urandom_range(0, 3));
      r.chain_slot = 4'($urandom_range(0, 15));
      r.lower_util = $urandom;
      r.upper_util = $urandom;
      r.quad_coef = $urandom;
      r.lin_coef = $urandom;
      r.floor_loss = 48'({$urandom, $urandom});
      r.sum_of_periods = $urandom;
      r.task_slot = 4'($urandom_range(0, 15));
      r.task_multiplier = 16'($urandom_range(1, 65535));
      r.util_request = $urandom;
      return r;
   endfunction

   function automatic req_type chain_item(int slot, logic [31:0] lo, logic [31:0] hi,
                                          logic [31:0] a, logic [31:0] b,
                                          logic [47:0] fl, logic [31:0] y);
      req_type r;
      r = noise_item();
      r.action = ACT_LOAD_CHAIN;
      r.chain_slot = 4'(slot);
      r.lower_util = lo;
      r.upper_util = hi;
      r.quad_coef = a;
      r.lin_coef = b;
      r.floor_loss = fl;
      r.sum_of_periods = y;
      return r;
   endfunction

   function automatic req_type query_item(logic [31:0] u);
      req_type r;
      r = noise_item();
      r.action = ACT_QUERY;
      r.util_request = u;
      return r;
   endfunction

   // Mostly queries aimed at the chain bounds, with loads and unknown actions mixed in.
   function automatic req_type random_item();
      req_type r;
      int pick;
      int c;
      logic [31:0] lo;
      r = noise_item();
      pick = $urandom_range(0, 99);
      c = $urandom_range(0, 15);
      if (pick < 10) begin
         r.action = ACT_LOAD_CHAIN;
         if ($urandom_range(0, 2) != 0) begin
            lo = $urandom_range(0, 32'h2000_0000);
            r.lower_util = lo;
            r.upper_util = lo + $urandom_range(0, 32'h4000_0000);
         end
      end else if (pick < 20) begin
         r.action = ACT_LOAD_MULT;
      end else if (pick < 24) begin
         r.action = 2'd3;
      end else begin
         r.action = ACT_QUERY;
         case ($urandom_range(0, 4))
            0, 1: r.util_request = sb.low_t[c] + $urandom_range(0, 32'h2000_0000);
            2: r.util_request = sb.high_t[c];
            3: r.util_request = sb.high_t[c] + 1;
            default: r.util_request = $urandom;
         endcase
      end
      return r;
   endfunction

   initial begin
      req_type r;
      int ph_chains[6];
      int ph_tasks[6];
      int hold_at;
      // Phases that use more than two tasks search only chains 0 to 3.
      ph_chains = '{4, 1, 0, 31, 17, 3};
      ph_tasks = '{16, 1, 7, 0, 2, 31};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Nothing loaded yet: the query is rejected and the unknown action is dropped.
      send_req(query_item(32'h0));
      r = noise_item();
      r.action = 2'd3;
      send_req(r);
      send_req(chain_item(0, 32'h1000_0000, 32'h2000_0000, '1, '0,
                          48'h7FFF_FFFF_FFFF, '1));
      send_req(query_item(32'h0FFF_FFFF));
      send_req(query_item(32'h1000_0000));
      send_req(query_item('1));
      drain();

      // Fill every chain, every multiplier of chains 0 to 3 and the second task's
      // multiplier of the others, so that no query reads an unwritten entry.
      // Chain 0 gets zero bounds so a zero request clamps to zero utilization.
      send_req(chain_item(0, 32'h0, 32'h0, $urandom, $urandom,
                          48'({$urandom, $urandom}), '1));
      for (int c = 1; c < 16; c++)
         send_req(chain_item(c, c << 27, (c << 27) + $urandom_range(32'h0400_0000,
                             32'h4000_0000), $urandom, $urandom,
                             48'({$urandom, $urandom}), $urandom));
      calm_send = 1;
      for (int c = 0; c < 16; c++)
         for (int t = 0; t < 16; t++) begin
            if (c < 4 || t == 1) begin
               r = noise_item();
               r.action = ACT_LOAD_MULT;
               r.chain_slot = 4'(c);
               r.task_slot = 4'(t);
               r.task_multiplier = (c == 0) ? 16'hFFFF :
                                   ((c == 1) ? 16'd1 : r.task_multiplier);
               send_req(r);
            end
         end
      calm_send = 0;
      drain();
      write_csr(CSR_CHAINS_IN_USE, 5'd16);
      write_csr(CSR_TASKS_IN_USE, 5'd2);

      send_req(query_item(32'h0));
      // A reload with a higher bound must not raise the running minimum.
      send_req(chain_item(0, 32'h0800_0000, 32'h0800_0000, '0, '0, '0, '1));
      send_req(query_item(32'h0));
      // Two identical chains: the earlier index wins the tie.
      send_req(chain_item(6, 32'h3000_0000, 32'h3800_0000, 32'h0100_0000, 32'h0300_0000,
                          48'h8000_0000_0000, 32'h0001_0000));
      send_req(chain_item(7, 32'h3000_0000, 32'h3800_0000, 32'h0100_0000, 32'h0300_0000,
                          48'h8000_0000_0000, 32'h0001_0000));
      send_req(query_item(32'h3400_0000));
      send_req(query_item('1));
      // Largest coefficients: the loss saturates, or goes far negative.
      send_req(chain_item(1, 32'h0, '1, '1, '0, '0, 32'h0));
      send_req(chain_item(5, 32'h0, '1, '0, '1, 48'h7FFF_FFFF_FFFF, '1));
      send_req(query_item('1));
      send_req(query_item(32'hFFFF_FFFE));

      for (int p = 0; p < 6; p++) begin
         drain();
         write_csr(CSR_CHAINS_IN_USE, CFG_W'(ph_chains[p]));
         write_csr(CSR_TASKS_IN_USE, CFG_W'(ph_tasks[p]));
         calm_send = (p == 2);
         calm_recv = (p == 4);
         hold_at = $urandom_range(3, 11);
         for (int i = 0; i < 15; i++) begin
            if (i == hold_at) drain();
            send_req(random_item());
         end
      end

      drain();
      repeat (250) @(posedge clock);
      if (sb.errors == 0 && sb.idle()) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* sim.f */
design/eps_pkg.sv
design/eps_ram.sv
design/eps_datapath.sv
design/eps_controller.sv
design/elastic_period_selector.sv
design/eps_checker.sv
sim/tb_elastic_period_selector.sv
